@@ rtl/adpe_pkg.sv @@
// Package for the data-processing execute stage: widths, field codes, flag
// positions, status codes and the condition-check function.
// No dependencies.
`default_nettype none

package adpe_pkg;

    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 4;
    localparam int FLAGS_W   = 4;
    localparam int STATUS_W  = 2;
    localparam int SHAMT_W   = 8;

    // NZCV bit positions
    localparam int FLAG_N = 3;
    localparam int FLAG_Z = 2;
    localparam int FLAG_C = 1;
    localparam int FLAG_V = 0;

    // status codes
    localparam logic [STATUS_W-1:0] ST_EXEC      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_COND_FAIL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_DP    = 2'd2;

    // data-processing opcodes
    localparam logic [3:0] OP_AND = 4'h0;
    localparam logic [3:0] OP_EOR = 4'h1;
    localparam logic [3:0] OP_SUB = 4'h2;
    localparam logic [3:0] OP_RSB = 4'h3;
    localparam logic [3:0] OP_ADD = 4'h4;
    localparam logic [3:0] OP_ADC = 4'h5;
    localparam logic [3:0] OP_SBC = 4'h6;
    localparam logic [3:0] OP_RSC = 4'h7;
    localparam logic [3:0] OP_TST = 4'h8;
    localparam logic [3:0] OP_TEQ = 4'h9;
    localparam logic [3:0] OP_CMP = 4'hA;
    localparam logic [3:0] OP_CMN = 4'hB;
    localparam logic [3:0] OP_ORR = 4'hC;
    localparam logic [3:0] OP_MOV = 4'hD;
    localparam logic [3:0] OP_BIC = 4'hE;
    localparam logic [3:0] OP_MVN = 4'hF;

    // shift types
    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    // condition codes
    localparam logic [3:0] COND_EQ = 4'h0;
    localparam logic [3:0] COND_NE = 4'h1;
    localparam logic [3:0] COND_CS = 4'h2;
    localparam logic [3:0] COND_CC = 4'h3;
    localparam logic [3:0] COND_MI = 4'h4;
    localparam logic [3:0] COND_PL = 4'h5;
    localparam logic [3:0] COND_VS = 4'h6;
    localparam logic [3:0] COND_VC = 4'h7;
    localparam logic [3:0] COND_HI = 4'h8;
    localparam logic [3:0] COND_LS = 4'h9;
    localparam logic [3:0] COND_GE = 4'hA;
    localparam logic [3:0] COND_LT = 4'hB;
    localparam logic [3:0] COND_GT = 4'hC;
    localparam logic [3:0] COND_LE = 4'hD;
    localparam logic [3:0] COND_AL = 4'hE;
    localparam logic [3:0] COND_NV = 4'hF;

    typedef struct packed {
        logic [DATA_W-1:0] operand;
        logic              carry;
    } t_shift_res;

    function automatic logic cond_pass(input logic [3:0] cond,
                                       input logic [FLAGS_W-1:0] f);
        logic n, z, c, v, pass;
        n = f[FLAG_N];
        z = f[FLAG_Z];
        c = f[FLAG_C];
        v = f[FLAG_V];
        unique case (cond)
            COND_EQ: pass = z;
            COND_NE: pass = !z;
            COND_CS: pass = c;
            COND_CC: pass = !c;
            COND_MI: pass = n;
            COND_PL: pass = !n;
            COND_VS: pass = v;
            COND_VC: pass = !v;
            COND_HI: pass = c && !z;
            COND_LS: pass = !c || z;
            COND_GE: pass = (n == v);
            COND_LT: pass = (n != v);
            COND_GT: pass = !z && (n == v);
            COND_LE: pass = z || (n != v);
            default: pass = 1'b1;
        endcase
        return pass;
    endfunction

endpackage

`default_nettype wire

@@ rtl/adpe_in_if.sv @@
// Request channel of the execute stage: valid/ready plus instruction and
// operand values. Depends on adpe_pkg.
`default_nettype none

interface adpe_in_if import adpe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] instruction_word;
    logic [DATA_W-1:0] first_operand_value;
    logic [DATA_W-1:0] shifted_register_value;
    logic [DATA_W-1:0] shift_amount_register_value;

    modport source (
        output valid, instruction_word, first_operand_value,
               shifted_register_value, shift_amount_register_value,
        input  ready
    );
    modport sink (
        input  valid, instruction_word, first_operand_value,
               shifted_register_value, shift_amount_register_value,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/adpe_out_if.sv @@
// Result channel of the execute stage: valid/ready plus result, write enable,
// destination, flags and status. Depends on adpe_pkg.
`default_nettype none

interface adpe_out_if import adpe_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [DATA_W-1:0]    result_value;
    logic                 write_enable;
    logic [REG_IDX_W-1:0] destination_index;
    logic [FLAGS_W-1:0]   flags_after;
    logic [STATUS_W-1:0]  status;

    modport source (
        output valid, result_value, write_enable, destination_index,
               flags_after, status,
        input  ready
    );
    modport sink (
        input  valid, result_value, write_enable, destination_index,
               flags_after, status,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/adpe_shifter.sv @@
// Barrel shifter: forms the shifter operand and its carry out from the
// instruction word, Rm and Rs[7:0]. Depends on adpe_pkg.
`default_nettype none

module adpe_shifter import adpe_pkg::*; (
    input  wire logic [DATA_W-1:0]  i_instr,
    input  wire logic [DATA_W-1:0]  i_rm,
    input  wire logic [SHAMT_W-1:0] i_rs_low,
    input  wire logic               i_carry,
    output t_shift_res              o_shift
);

    logic                 imm_sh;
    logic [4:0]           s5;
    logic                 zero_amt;
    logic                 big_amt;
    logic [5:0]           amt;
    logic [4:0]           rot_amt;
    logic [4:0]           imm_rot;
    logic [2*DATA_W-1:0]  lsl_t;
    logic [2*DATA_W-1:0]  lsr_t;
    logic signed [2*DATA_W-1:0] asr_t;
    logic [2*DATA_W-1:0]  ror_t;
    logic [2*DATA_W-1:0]  imm_t;

    assign imm_sh  = !i_instr[4];
    assign s5      = i_instr[11:7];
    // register amounts above 32 behave like "shifted out entirely"
    assign big_amt = (i_rs_low[7:6] != 2'd0) || (i_rs_low[5] && (i_rs_low[4:0] != 5'd0));
    assign zero_amt = imm_sh ? (s5 == 5'd0) : (i_rs_low == '0);

    always_comb begin
        if (imm_sh) begin
            amt = (s5 == 5'd0) ? 6'd32 : {1'b0, s5};
        end else begin
            amt = big_amt ? 6'd32 : i_rs_low[5:0];
        end
    end

    assign rot_amt = imm_sh ? s5 : i_rs_low[4:0];
    assign imm_rot = {i_instr[11:8], 1'b0};

    assign lsl_t = {{DATA_W{1'b0}}, i_rm} << amt;
    assign lsr_t = {i_rm, {DATA_W{1'b0}}} >> amt;
    assign asr_t = $signed({i_rm, {DATA_W{1'b0}}}) >>> amt;
    assign ror_t = {i_rm, i_rm} >> rot_amt;
    assign imm_t = {{(DATA_W-8){1'b0}}, i_instr[7:0],
                    {(DATA_W-8){1'b0}}, i_instr[7:0]} >> imm_rot;

    always_comb begin
        o_shift.operand = i_rm;
        o_shift.carry   = i_carry;
        if (i_instr[25]) begin
            o_shift.operand = imm_t[DATA_W-1:0];
            o_shift.carry   = (imm_rot == 5'd0) ? i_carry : imm_t[DATA_W-1];
        end else begin
            case (i_instr[6:5])
                SH_LSL: begin
                    if (zero_amt) begin
                        o_shift.operand = i_rm;
                        o_shift.carry   = i_carry;
                    end else if (!imm_sh && big_amt) begin
                        o_shift.operand = '0;
                        o_shift.carry   = 1'b0;
                    end else begin
                        o_shift.operand = lsl_t[DATA_W-1:0];
                        o_shift.carry   = lsl_t[DATA_W];
                    end
                end
                SH_LSR: begin
                    if (!imm_sh && zero_amt) begin
                        o_shift.operand = i_rm;
                        o_shift.carry   = i_carry;
                    end else if (!imm_sh && big_amt) begin
                        o_shift.operand = '0;
                        o_shift.carry   = 1'b0;
                    end else begin
                        o_shift.operand = lsr_t[2*DATA_W-1:DATA_W];
                        o_shift.carry   = lsr_t[DATA_W-1];
                    end
                end
                SH_ASR: begin
                    if (!imm_sh && zero_amt) begin
                        o_shift.operand = i_rm;
                        o_shift.carry   = i_carry;
                    end else begin
                        o_shift.operand = asr_t[2*DATA_W-1:DATA_W];
                        o_shift.carry   = asr_t[DATA_W-1];
                    end
                end
                default: begin
                    if (imm_sh && zero_amt) begin
                        // RRX
                        o_shift.operand = {i_carry, i_rm[DATA_W-1:1]};
                        o_shift.carry   = i_rm[0];
                    end else if (zero_amt) begin
                        o_shift.operand = i_rm;
                        o_shift.carry   = i_carry;
                    end else begin
                        o_shift.operand = ror_t[DATA_W-1:0];
                        o_shift.carry   = ror_t[DATA_W-1];
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/arm_data_processing_execute.sv @@
// ARMv5 data-processing execute stage: condition check, barrel shifter, ALU
// and NZCV flag register. Depends on adpe_pkg, adpe_in_if, adpe_out_if and
// adpe_shifter.
//
// Usage:
//   i_req  - request channel (sink): instruction word with Rn, Rm and Rs values.
//   o_res  - result channel (source): result, write enable, Rd index, NZCV
//            after the instruction and status (executed / condition failed /
//            not a data-processing instruction).
//   A request moves through two register stages: an input register, then the
//   shifter/ALU logic into the result register. A request leaves the input
//   register as soon as the result register is free or being emptied;
//   throughput is one request per cycle while o_res is not held off.
//   The NZCV register is updated when a request leaves the input register,
//   so the request behind it already sees the new flags.
//   Stall: when o_res is held off, the result register holds its contents
//   and the input register can still fill; i_req.ready then drops until the
//   result is taken. Nothing is lost or duplicated.
//   Reset (synchronous, active low): both stages empty, NZCV cleared.
`default_nettype none

module arm_data_processing_execute import adpe_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    adpe_in_if.sink   i_req,
    adpe_out_if.source o_res
);

    // ---------------- input register ----------------
    logic                r_in_valid;
    logic [DATA_W-1:0]   r_ins;
    logic [DATA_W-1:0]   r_rn;
    logic [DATA_W-1:0]   r_rm;
    logic [SHAMT_W-1:0]  r_rs;

    // ---------------- result register ----------------
    logic                 r_out_valid;
    logic [DATA_W-1:0]    r_result;
    logic                 r_we;
    logic [REG_IDX_W-1:0] r_rd;
    logic [FLAGS_W-1:0]   r_flags_out;
    logic [STATUS_W-1:0]  r_status;

    // architectural NZCV
    logic [FLAGS_W-1:0]   r_flags;

    logic                 advance;
    logic                 accept;

    // decode
    logic [3:0]           cond;
    logic [3:0]           opc;
    logic                 sbit;
    logic                 not_dp;
    logic                 exec;
    logic                 is_cmp_class;
    logic                 arith;
    logic                 cin;

    t_shift_res           shift;

    // adder
    logic [DATA_W-1:0]    add_x;
    logic [DATA_W-1:0]    add_y;
    logic                 add_c;
    logic [DATA_W:0]      sum;
    logic                 overflow;
    logic [DATA_W-1:0]    alu_res;

    logic [DATA_W-1:0]    n_result;
    logic                 n_we;
    logic [FLAGS_W-1:0]   n_flags;
    logic [STATUS_W-1:0]  n_status;
    logic                 flags_wr;

    // item moves from input to result register when the result slot frees up
    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || advance;
    assign accept      = i_req.valid && i_req.ready;

    assign cond = r_ins[31:28];
    assign opc  = r_ins[24:21];
    assign sbit = r_ins[20];
    assign cin  = r_flags[FLAG_C];

    assign is_cmp_class = (opc[3:2] == 2'b10);

    // other classes, unconditional space, misc space (TST..CMN without S),
    // multiply / extra load-store space
    assign not_dp = (r_ins[27:26] != 2'b00) || (cond == COND_NV)
                    || (is_cmp_class && !sbit)
                    || (!r_ins[25] && r_ins[7] && r_ins[4]);
    assign exec   = !not_dp && cond_pass(cond, r_flags);

    adpe_shifter u_shifter (
        .i_instr  (r_ins),
        .i_rm     (r_rm),
        .i_rs_low (r_rs),
        .i_carry  (cin),
        .o_shift  (shift)
    );

    // adder operand selection
    always_comb begin
        add_x = r_rn;
        add_y = shift.operand;
        add_c = 1'b0;
        arith = 1'b0;
        case (opc) inside
            OP_SUB, OP_CMP: begin
                add_x = r_rn;          add_y = ~shift.operand; add_c = 1'b1; arith = 1'b1;
            end
            OP_RSB: begin
                add_x = shift.operand; add_y = ~r_rn;          add_c = 1'b1; arith = 1'b1;
            end
            OP_ADD, OP_CMN: begin
                add_x = r_rn;          add_y = shift.operand;  add_c = 1'b0; arith = 1'b1;
            end
            OP_ADC: begin
                add_x = r_rn;          add_y = shift.operand;  add_c = cin;  arith = 1'b1;
            end
            OP_SBC: begin
                add_x = r_rn;          add_y = ~shift.operand; add_c = cin;  arith = 1'b1;
            end
            OP_RSC: begin
                add_x = shift.operand; add_y = ~r_rn;          add_c = cin;  arith = 1'b1;
            end
            default: begin
                add_x = r_rn;
                add_y = shift.operand;
                add_c = 1'b0;
                arith = 1'b0;
            end
        endcase
    end

    assign sum      = {1'b0, add_x} + {1'b0, add_y} + {{DATA_W{1'b0}}, add_c};
    assign overflow = (add_x[DATA_W-1] ^ sum[DATA_W-1]) & (add_y[DATA_W-1] ^ sum[DATA_W-1]);

    always_comb begin
        case (opc) inside
            OP_AND, OP_TST: alu_res = r_rn & shift.operand;
            OP_EOR, OP_TEQ: alu_res = r_rn ^ shift.operand;
            OP_ORR:         alu_res = r_rn | shift.operand;
            OP_MOV:         alu_res = shift.operand;
            OP_BIC:         alu_res = r_rn & ~shift.operand;
            OP_MVN:         alu_res = ~shift.operand;
            default:        alu_res = sum[DATA_W-1:0];
        endcase
    end

    // result and flag update; skipped instructions leave NZCV alone
    always_comb begin
        n_we     = exec && !is_cmp_class;
        n_result = n_we ? alu_res : '0;
        n_status = not_dp ? ST_NOT_DP : (exec ? ST_EXEC : ST_COND_FAIL);
        flags_wr = exec && sbit;
        n_flags  = r_flags;
        if (flags_wr) begin
            n_flags[FLAG_N] = alu_res[DATA_W-1];
            n_flags[FLAG_Z] = (alu_res == '0);
            // logical ops take the shifter carry and keep V
            n_flags[FLAG_C] = arith ? sum[DATA_W] : shift.carry;
            n_flags[FLAG_V] = arith ? overflow : r_flags[FLAG_V];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance && flags_wr) begin
                r_flags <= n_flags;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ins <= i_req.instruction_word;
            r_rn  <= i_req.first_operand_value;
            r_rm  <= i_req.shifted_register_value;
            r_rs  <= i_req.shift_amount_register_value[SHAMT_W-1:0];
        end
        if (advance) begin
            r_result    <= n_result;
            r_we        <= n_we;
            r_rd        <= r_ins[15:12];
            r_flags_out <= n_flags;
            r_status    <= n_status;
        end
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.result_value      = r_result;
    assign o_res.write_enable      = r_we;
    assign o_res.destination_index = r_rd;
    assign o_res.flags_after       = r_flags_out;
    assign o_res.status            = r_status;

endmodule

`default_nettype wire

@@ tb/adpe_exec_checker.sv @@
`timescale 1ns / 1ps
// Checker for the data-processing execute stage. It watches the request and result
// channels, predicts each retired instruction and compares every field.
// Depends on adpe_pkg, adpe_in_if and adpe_out_if.

module adpe_exec_checker import adpe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    adpe_in_if   i_req,
    adpe_out_if  i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);

    typedef struct packed {
        logic [DATA_W-1:0]    result_value;
        logic                 write_enable;
        logic [REG_IDX_W-1:0] destination_index;
        logic [FLAGS_W-1:0]   flags_after;
        logic [STATUS_W-1:0]  status;
    } t_exec_out;

    t_exec_out          retire_q[$];
    logic [FLAGS_W-1:0] nzcv_shadow;

    function automatic logic [DATA_W-1:0] ror32(input logic [DATA_W-1:0] x,
                                                input logic [4:0] n);
        return (x >> n) | (x << (DATA_W - n));
    endfunction

    function automatic t_exec_out execute_instr(
        input logic [DATA_W-1:0]  ins, rn, rm, rs,
        input logic [FLAGS_W-1:0] f
    );
        t_exec_out          r;
        logic [3:0]         opc, cond;
        logic               n, z, c, v, pass, cin, sh_c, arith, add_c;
        logic [SHAMT_W-1:0] amt;
        logic [4:0]         rot;
        logic [DATA_W-1:0]  op2, x, y, res;
        logic [DATA_W:0]    sum;
        logic [FLAGS_W-1:0] nf;
        r = '0;
        r.destination_index = ins[15:12];
        r.flags_after = f;
        opc  = ins[24:21];
        cond = ins[31:28];
        n = f[FLAG_N];
        z = f[FLAG_Z];
        c = f[FLAG_C];
        v = f[FLAG_V];
        cin = c;
        case (cond)
            COND_EQ: pass = z;
            COND_NE: pass = !z;
            COND_CS: pass = c;
            COND_CC: pass = !c;
            COND_MI: pass = n;
            COND_PL: pass = !n;
            COND_VS: pass = v;
            COND_VC: pass = !v;
            COND_HI: pass = c && !z;
            COND_LS: pass = !c || z;
            COND_GE: pass = (n == v);
            COND_LT: pass = (n != v);
            COND_GT: pass = !z && (n == v);
            COND_LE: pass = z || (n != v);
            default: pass = 1'b1;
        endcase

        if (ins[27:26] != 2'b00 || cond == COND_NV
                || (opc[3:2] == 2'b10 && !ins[20])
                || (!ins[25] && ins[7] && ins[4])) begin
            r.status = ST_NOT_DP;
        end else if (!pass) begin
            r.status = ST_COND_FAIL;
        end else begin
            // shifter operand and carry
            if (ins[25]) begin
                rot  = {ins[11:8], 1'b0};
                op2  = ror32({24'b0, ins[7:0]}, rot);
                sh_c = (rot == 0) ? cin : op2[31];
            end else begin
                amt = ins[4] ? rs[7:0] : {3'b000, ins[11:7]};
                // immediate LSR/ASR #0 encode a shift by 32
                if (!ins[4] && amt == 0 && (ins[6:5] == SH_LSR || ins[6:5] == SH_ASR))
                    amt = 8'd32;
                if (amt == 0) begin
                    if (!ins[4] && ins[6:5] == SH_ROR) begin
                        op2  = {cin, rm[31:1]};  // RRX
                        sh_c = rm[0];
                    end else begin
                        op2  = rm;
                        sh_c = cin;
                    end
                end else begin
                    case (ins[6:5])
                        SH_LSL: begin
                            op2 = rm << amt;
                            if (amt < 32) sh_c = rm[32 - amt];
                            else          sh_c = (amt == 32) && rm[0];
                        end
                        SH_LSR: begin
                            op2 = rm >> amt;
                            if (amt < 32) sh_c = rm[amt - 1];
                            else          sh_c = (amt == 32) && rm[31];
                        end
                        SH_ASR: begin
                            if (amt < 32) begin
                                op2  = $signed(rm) >>> amt;
                                sh_c = rm[amt - 1];
                            end else begin
                                op2  = {DATA_W{rm[31]}};
                                sh_c = rm[31];
                            end
                        end
                        default: begin
                            if (amt[4:0] == 0) begin
                                op2  = rm;
                                sh_c = rm[31];
                            end else begin
                                op2  = ror32(rm, amt[4:0]);
                                sh_c = rm[amt[4:0] - 1];
                            end
                        end
                    endcase
                end
            end

            arith = 1'b1;
            add_c = 1'b0;
            x = rn;
            y = op2;
            res = '0;
            case (opc) inside
                OP_AND, OP_TST: begin res = rn & op2;  arith = 1'b0; end
                OP_EOR, OP_TEQ: begin res = rn ^ op2;  arith = 1'b0; end
                OP_SUB, OP_CMP: begin y = ~op2; add_c = 1'b1; end
                OP_RSB:         begin x = op2; y = ~rn; add_c = 1'b1; end
                OP_ADD, OP_CMN: add_c = 1'b0;
                OP_ADC:         add_c = cin;
                OP_SBC:         begin y = ~op2; add_c = cin; end
                OP_RSC:         begin x = op2; y = ~rn; add_c = cin; end
                OP_ORR:         begin res = rn | op2;  arith = 1'b0; end
                OP_MOV:         begin res = op2;       arith = 1'b0; end
                OP_BIC:         begin res = rn & ~op2; arith = 1'b0; end
                default:        begin res = ~op2;      arith = 1'b0; end
            endcase
            sum = {1'b0, x} + {1'b0, y} + {{DATA_W{1'b0}}, add_c};
            if (arith) res = sum[DATA_W-1:0];

            nf = f;
            nf[FLAG_N] = res[31];
            nf[FLAG_Z] = (res == '0);
            nf[FLAG_C] = arith ? sum[DATA_W] : sh_c;
            if (arith) nf[FLAG_V] = (x[31] ^ res[31]) & (y[31] ^ res[31]);
            if (ins[20]) r.flags_after = nf;

            r.write_enable = (opc[3:2] != 2'b10);
            r.result_value = r.write_enable ? res : '0;
            r.status = ST_EXEC;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_exec_out want;
        if (!i_rst_n) begin
            retire_q.delete();
            nzcv_shadow  = '0;
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            // results retire before this edge's request is predicted
            if (i_res.valid && i_res.ready) begin
                if (retire_q.size() == 0) begin
                    report_mismatch("result with no request pending", i_res.result_value, '0);
                end else begin
                    want = retire_q.pop_front();
                    o_checked++;
                    if (i_res.result_value !== want.result_value)
                        report_mismatch("result_value", i_res.result_value, want.result_value);
                    if (i_res.write_enable !== want.write_enable)
                        report_mismatch("write_enable", 32'(i_res.write_enable),
                                        32'(want.write_enable));
                    if (i_res.destination_index !== want.destination_index)
                        report_mismatch("destination_index", 32'(i_res.destination_index),
                                        32'(want.destination_index));
                    if (i_res.flags_after !== want.flags_after)
                        report_mismatch("flags_after", 32'(i_res.flags_after),
                                        32'(want.flags_after));
                    if (i_res.status !== want.status)
                        report_mismatch("status", 32'(i_res.status), 32'(want.status));
                end
            end
            if (i_req.valid && i_req.ready) begin
                want = execute_instr(i_req.instruction_word, i_req.first_operand_value,
                                     i_req.shifted_register_value,
                                     i_req.shift_amount_register_value, nzcv_shadow);
                nzcv_shadow = want.flags_after;
                retire_q.push_back(want);
            end
        end
        o_pending = retire_q.size();
    end

endmodule

@@ tb/arm_data_processing_execute_tb.sv @@
`timescale 1ns / 1ps
// Top of the execute-stage testbench: clock, reset, request stimulus and result
// back-pressure. Depends on adpe_pkg, the channel interfaces and adpe_exec_checker.

module arm_data_processing_execute_tb;
    import adpe_pkg::*;

    localparam int N_RANDOM     = 400;
    localparam int N_CALM_TAIL  = 80;      // final requests with no idling at all
    localparam int CYCLE_LIMIT  = 200_000; // watchdog limit for the whole run
    localparam int DRAIN_CYCLES = 8;       // settling time after the last result is checked

    logic clk;
    logic rst_n;
    bit   idle_on;     // enables sender gaps and receiver stalls
    int   sent;
    int   cycle_count;
    int   fail_count;
    int   pending;
    int   checked;

    adpe_in_if  req_if ();
    adpe_out_if res_if ();

    arm_data_processing_execute dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    adpe_exec_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial cycle_count = 0;
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d requests outstanding", cycle_count, pending);
            $display("arm_data_processing_execute_tb: FAIL");
            $finish;
        end
    end

    // Data-processing encoding: cond | 00 | I | opcode | S | Rn | Rd | operand2.
    // operand2 is {rot, imm8}, {shamt5, type, 0, Rm} or {Rs, 0, type, 1, Rm}.
    function automatic logic [31:0] dp_word(input logic [3:0] cond, input logic imm,
                                            input logic [3:0] opc, input logic s,
                                            input logic [3:0] rn, input logic [3:0] rd,
                                            input logic [11:0] op2);
        return {cond, 2'b00, imm, opc, s, rn, rd, op2};
    endfunction

    // Register values: corners now and then, otherwise anything.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Drive one request at the falling edge and hold it until accepted.
    // valid stays high into the next request unless a gap is taken.
    task automatic send_req(input logic [31:0] ins, input logic [31:0] rn,
                            input logic [31:0] rm, input logic [31:0] rs);
        int gap;
        @(negedge clk);
        req_if.valid                       = 1'b1;
        req_if.instruction_word            = ins;
        req_if.first_operand_value         = rn;
        req_if.shifted_register_value      = rm;
        req_if.shift_amount_register_value = rs;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        sent++;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            @(negedge clk);
            req_if.valid            = 1'b0;
            req_if.instruction_word = $urandom();  // payload is don't-care while idle
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Result side: ready drops in random bursts while idling is enabled.
    initial begin
        int stall;
        stall = 0;
        res_if.ready = 1'b1;
        forever begin
            @(negedge clk);
            if (stall == 0 && idle_on && $urandom_range(0, 5) == 0)
                stall = $urandom_range(1, 19);
            if (stall > 0) begin
                res_if.ready = 1'b0;
                stall--;
            end else begin
                res_if.ready = 1'b1;
            end
        end
    end

    initial begin
        logic [31:0] ins;
        logic [31:0] rs;
        rst_n   = 1'b0;
        idle_on = 1'b0;
        sent    = 0;
        req_if.valid                       = 1'b0;
        req_if.instruction_word            = '0;
        req_if.first_operand_value         = '0;
        req_if.shifted_register_value      = '0;
        req_if.shift_amount_register_value = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ---- directed: every opcode, each shifter form, the skip paths ----
        // MOVS #0 sets Z; ADDS 0x7FFFFFFF+1 sets N and V
        send_req(dp_word(COND_AL, 1'b1, OP_MOV, 1'b1, 4'd0, 4'd0, 12'h000), 0, 0, 0);
        send_req(dp_word(COND_AL, 1'b1, OP_ADD, 1'b1, 4'd1, 4'd1, 12'h001),
                 32'h7FFF_FFFF, 0, 0);
        // ANDS with rotated immediate: C from bit 31 of the rotate, V left as is
        send_req(dp_word(COND_AL, 1'b1, OP_AND, 1'b1, 4'd2, 4'd2, 12'h1FF),
                 32'hFFFF_FFFF, 0, 0);
        // EOR, LSL #31, no flags
        send_req(dp_word(COND_AL, 1'b0, OP_EOR, 1'b0, 4'd3, 4'd3,
                         {5'd31, SH_LSL, 1'b0, 4'd4}), 0, 32'hFFFF_FFFF, 0);
        // LSR #0 is LSR #32; ASR #0 is ASR #32; ROR #0 is RRX
        send_req(dp_word(COND_AL, 1'b0, OP_SUB, 1'b1, 4'd4, 4'd5,
                         {5'd0, SH_LSR, 1'b0, 4'd5}), 0, 32'h8000_0000, 0);
        send_req(dp_word(COND_AL, 1'b0, OP_RSB, 1'b1, 4'd5, 4'd6,
                         {5'd0, SH_ASR, 1'b0, 4'd6}), 32'hFFFF_FFFF, 32'h8000_0000, 0);
        send_req(dp_word(COND_AL, 1'b0, OP_ADC, 1'b1, 4'd6, 4'd7,
                         {5'd0, SH_ROR, 1'b0, 4'd7}), 32'hFFFF_FFFF, 32'h0000_0001, 0);
        // register shifts: zero low byte with junk above, 32, 33, 255, ROR by 32, ROR 5
        send_req(dp_word(COND_AL, 1'b0, OP_SBC, 1'b1, 4'd7, 4'd8,
                         {4'd8, 1'b0, SH_LSL, 1'b1, 4'd9}), 0, 32'h1234_5678, 32'hFFFF_FF00);
        send_req(dp_word(COND_AL, 1'b0, OP_RSC, 1'b1, 4'd8, 4'd9,
                         {4'd9, 1'b0, SH_LSR, 1'b1, 4'd10}), 5, 32'h8000_0001, 32);
        send_req(dp_word(COND_AL, 1'b0, OP_TST, 1'b1, 4'd9, 4'd10,
                         {4'd10, 1'b0, SH_LSL, 1'b1, 4'd11}), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 33);
        send_req(dp_word(COND_AL, 1'b0, OP_TEQ, 1'b1, 4'd10, 4'd11,
                         {4'd11, 1'b0, SH_ASR, 1'b1, 4'd12}), 0, 32'h8000_0000, 32'hFF);
        send_req(dp_word(COND_AL, 1'b0, OP_CMP, 1'b1, 4'd11, 4'd12,
                         {4'd12, 1'b0, SH_ROR, 1'b1, 4'd13}), 0, 32'h8000_0000, 32);
        send_req(dp_word(COND_AL, 1'b0, OP_CMN, 1'b1, 4'd12, 4'd13,
                         {4'd13, 1'b0, SH_ROR, 1'b1, 4'd14}), 32'hFFFF_FFF0, 32'h11,
                 32'hABCD_0005);
        send_req(dp_word(COND_AL, 1'b1, OP_ORR, 1'b1, 4'd13, 4'd14, 12'hFFF), 0, 0, 0);
        // PC as destination with S: handled like any register
        send_req(dp_word(COND_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd15,
                         {5'd1, SH_LSR, 1'b0, 4'd1}), 0, 32'hFFFF_FFFF, 0);
        send_req(dp_word(COND_AL, 1'b0, OP_BIC, 1'b0, 4'd1, 4'd2,
                         {5'd4, SH_LSL, 1'b0, 4'd3}), 32'hFFFF_FFFF, 32'h0F0F_0F0F, 0);
        send_req(dp_word(COND_AL, 1'b1, OP_MVN, 1'b1, 4'd0, 4'd3, 12'h000), 0, 0, 0);
        // Z is clear now: EQ fails, LT depends on N and V
        send_req(dp_word(COND_EQ, 1'b1, OP_ADD, 1'b1, 4'd2, 4'd4, 12'h0FF), 1, 0, 0);
        send_req(dp_word(COND_LT, 1'b1, OP_ADD, 1'b1, 4'd2, 4'd4, 12'h0FF), 1, 0, 0);
        // not data-processing: load, MRS space, multiply space, cond NV
        send_req(32'hE591_2000, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333);
        send_req(32'hE10F_0000, 0, 0, 0);
        send_req(32'hE001_0291, 7, 9, 11);
        send_req(32'hF3A0_0000, 0, 0, 0);
        // most negative minus one overflows
        send_req(dp_word(COND_AL, 1'b1, OP_CMP, 1'b1, 4'd5, 4'd0, 12'h001),
                 32'h8000_0000, 0, 0);
        send_req(dp_word(COND_GE, 1'b1, OP_MOV, 1'b1, 4'd0, 4'd15, 12'h4FF), 0, 0, 0);

        // ---- random: mostly well-formed data-processing, some raw noise ----
        for (int i = 0; i < N_RANDOM; i++) begin
            idle_on = (i < N_RANDOM - N_CALM_TAIL) && ((i / 40) % 3 != 2);
            ins = $urandom();
            if ($urandom_range(0, 99) >= 8) begin
                ins[27:26] = 2'b00;
                if (ins[31:28] == COND_NV && $urandom_range(0, 3) != 0)
                    ins[31:28] = COND_AL;
                // compares need S, else they fall into the miscellaneous space
                if (ins[24:23] == 2'b10 && $urandom_range(0, 7) != 0)
                    ins[20] = 1'b1;
                // keep register shifts out of the multiply space most of the time
                if (!ins[25] && ins[4] && ins[7] && $urandom_range(0, 7) != 0)
                    ins[7] = 1'b0;
            end
            rs = $urandom();
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 4))
                    0:       rs[7:0] = 8'd0;
                    1:       rs[7:0] = 8'd1;
                    2:       rs[7:0] = 8'd31;
                    3:       rs[7:0] = 8'd32;
                    default: rs[7:0] = 8'd33;
                endcase
            end
            send_req(ins, pick_operand(), pick_operand(), rs);
        end
        idle_on = 1'b0;
        @(negedge clk);
        req_if.valid = 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d requests, %0d results compared: all opcodes, shifter forms,",
                 sent, checked);
        $display("condition codes, skipped and non data-processing words, with back-pressure");
        if (fail_count == 0 && pending == 0)
            $display("arm_data_processing_execute_tb: PASS");
        else
            $display("arm_data_processing_execute_tb: FAIL");
        $finish;
    end

endmodule
